[hdl/psa_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the pump switch assigner
package psa_pkg;
    localparam int MAX_PUMPS = 8;
    localparam int HOURS     = 24;
    localparam int HW        = 5;   // hour index width
    localparam int PW        = 3;   // pump index width
    localparam int CW        = 4;   // count width
    localparam int AW        = 6;   // signed allowance width
    localparam int ROW_W     = 8;
    localparam int ADDR_W    = 4;

    localparam logic [ADDR_W-1:0] REG_PUMP_COUNT = 4'h0;
    localparam logic [ADDR_W-1:0] REG_ACT_LIMIT  = 4'h4;
    localparam logic [ADDR_W-1:0] REG_SORT_EN    = 4'h8;

    localparam logic [CW-1:0] PUMP_COUNT_RST = 4'd8;
    localparam logic [4:0]    ACT_LIMIT_RST  = 5'd3;

    typedef struct packed {
        logic [ROW_W-1:0] pump_row;
        logic             feasible;
        logic [CW-1:0]    remaining_switches;
    } t_result;

    typedef struct packed {
        logic [HW-1:0] hour;
        logic [CW-1:0] pumps_on;
    } t_request;
endpackage

[hdl/psa_if.sv]
`timescale 1ns / 1ps
// valid/ready channel carrying one payload
interface psa_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/psa_ram.sv]
`timescale 1ns / 1ps
// generic single-port ram with registered read
module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hdl/pump_switch_assigner_top.sv]
`timescale 1ns / 1ps
// pump switch assigner top level: apb registers, sequencer and row store
// One transaction in gives one result out. After reset a clearing pass
// zeroes the row store, during which no transaction is taken. An hour
// h of 3 or more whose count changes goes from accept to result valid
// through these steps: fetch the previous row and count, read stored
// rows 1..h-1 to count transitions for every pump at once, insertion sort
// of up to 8 pumps using one shared compare (when sorting is enabled),
// greedy walk over the pumps, then store and present.
// Hours 1 and 2 skip the row scan. An unchanged count skips the scan, sort
// and walk, and an out of range hour is answered directly with a zero result.
// The next transaction is taken once the result has left the output register.
module pump_switch_assigner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    psa_if.sink         i_req,
    psa_if.source       o_res
);
    localparam int RD = psa_pkg::HOURS + 1;
    localparam int RA = $clog2(RD);

    logic [psa_pkg::CW-1:0] r_pump_count;
    logic [4:0]             r_act_limit;
    logic                   r_sort_en;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_count <= psa_pkg::PUMP_COUNT_RST;
            r_act_limit  <= psa_pkg::ACT_LIMIT_RST;
            r_sort_en    <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                psa_pkg::REG_PUMP_COUNT: r_pump_count <= pwdata[3:0];
                psa_pkg::REG_ACT_LIMIT:  r_act_limit  <= pwdata[4:0];
                psa_pkg::REG_SORT_EN:    r_sort_en    <= pwdata[0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr)
            psa_pkg::REG_PUMP_COUNT: prdata = {28'd0, r_pump_count};
            psa_pkg::REG_ACT_LIMIT:  prdata = {27'd0, r_act_limit};
            psa_pkg::REG_SORT_EN:    prdata = {31'd0, r_sort_en};
            default:                 prdata = '0;
        endcase
    end

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RDPREV, S_PREV, S_SCAN, S_SCANW, S_SORTI, S_SORTC,
        S_WALK, S_WRITE, S_OUT
    } t_state;

    t_state                         r_state;
    logic [RA-1:0]                  r_addr;
    logic                           r_we;
    logic [psa_pkg::ROW_W-1:0]      r_wrow;
    logic [psa_pkg::CW-1:0]         r_wcnt;
    logic [psa_pkg::ROW_W-1:0]      w_rrow;
    logic [psa_pkg::CW-1:0]         w_rcnt;

    psa_ram #(.WIDTH(psa_pkg::ROW_W), .DEPTH(RD)) u_rows (
        .i_clk(i_clk), .i_we(r_we), .i_addr(r_addr), .i_wdata(r_wrow), .o_rdata(w_rrow));
    psa_ram #(.WIDTH(psa_pkg::CW), .DEPTH(RD)) u_cnts (
        .i_clk(i_clk), .i_we(r_we), .i_addr(r_addr), .i_wdata(r_wcnt), .o_rdata(w_rcnt));

    logic [psa_pkg::HW-1:0]         r_hour;
    logic [psa_pkg::CW-1:0]         r_want;
    logic [psa_pkg::CW-1:0]         r_n;
    logic [psa_pkg::ROW_W-1:0]      r_row;
    logic [psa_pkg::ROW_W-1:0]      r_last;
    logic [psa_pkg::CW-1:0]         r_old;
    logic                           r_on;
    logic [psa_pkg::CW-1:0]         r_cnt;
    logic                           r_ok;
    logic signed [psa_pkg::AW-1:0]  r_a01 [psa_pkg::MAX_PUMPS];
    logic signed [psa_pkg::AW-1:0]  r_a10 [psa_pkg::MAX_PUMPS];
    logic [psa_pkg::PW-1:0]         r_ord [psa_pkg::MAX_PUMPS];
    logic [psa_pkg::CW-1:0]         r_i;
    logic [psa_pkg::CW-1:0]         r_k;
    logic [psa_pkg::PW-1:0]         r_v;
    logic                           r_scan_first;
    logic                           r_ovalid;
    psa_pkg::t_result               r_res;

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    // shared comparator: does pump v go before pump order[k-1]
    logic [psa_pkg::PW-1:0]        w_b;
    logic signed [psa_pkg::AW-1:0] w_pa, w_pb, w_sa, w_sb;
    logic                          w_first;
    always_comb begin
        w_b  = r_ord[r_k[psa_pkg::PW-1:0] - 3'd1];
        w_pa = r_on ? r_a01[r_v] : r_a10[r_v];
        w_pb = r_on ? r_a01[w_b] : r_a10[w_b];
        w_sa = r_on ? r_a10[r_v] : r_a01[r_v];
        w_sb = r_on ? r_a10[w_b] : r_a01[w_b];
        if (w_pa != w_pb)      w_first = w_pa > w_pb;
        else if (w_sa != w_sb) w_first = w_sa > w_sb;
        else                   w_first = r_v < w_b;
    end

    logic [psa_pkg::PW-1:0] w_q;
    logic                   w_qbit;
    logic signed [psa_pkg::AW-1:0] w_qallow;
    assign w_q      = r_ord[r_i[psa_pkg::PW-1:0]];
    assign w_qbit   = r_row[w_q];
    assign w_qallow = r_on ? r_a01[w_q] : r_a10[w_q];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
            r_we     <= 1'b1;
            r_wrow   <= '0;
            r_wcnt   <= '0;
        end else begin
            // store write: clearing pass, or the row of the finished hour
            r_we <= ((r_state == S_CLEAR) && (r_addr != RA'(RD - 1))) ||
                    (r_state == S_WRITE);
            if (o_res.valid && o_res.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == RA'(RD - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid && !r_ovalid) begin
                        r_hour <= i_req.data.hour;
                        r_want <= i_req.data.pumps_on;
                        r_n    <= (r_pump_count > psa_pkg::CW'(psa_pkg::MAX_PUMPS))
                                  ? psa_pkg::CW'(psa_pkg::MAX_PUMPS) : r_pump_count;
                        if (i_req.data.hour == '0 ||
                                i_req.data.hour > psa_pkg::HW'(psa_pkg::HOURS)) begin
                            r_res    <= '0;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_addr  <= RA'(i_req.data.hour - 1'b1);
                            r_state <= S_RDPREV;
                        end
                    end
                end
                S_RDPREV: r_state <= S_PREV;
                S_PREV: begin
                    for (int p = 0; p < psa_pkg::MAX_PUMPS; p++) begin
                        r_row[p] <= w_rrow[p] && (p < r_n);
                        r_a01[p] <= psa_pkg::AW'(r_act_limit);
                        r_a10[p] <= psa_pkg::AW'(r_act_limit);
                        r_ord[p] <= psa_pkg::PW'(p);
                    end
                    r_old <= w_rcnt;
                    r_on  <= r_want > w_rcnt;
                    r_cnt <= (r_want > w_rcnt) ? r_want - w_rcnt : w_rcnt - r_want;
                    r_ok  <= 1'b1;
                    if (r_want == w_rcnt) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_addr       <= RA'(1);
                        r_scan_first <= 1'b1;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // read rows 1..h-1 in turn, compare each with the one before
                    if (r_hour < psa_pkg::HW'(3)) begin
                        r_i     <= psa_pkg::CW'(1);
                        r_state <= S_SORTI;
                    end else begin
                        r_state <= S_SCANW;
                    end
                end
                S_SCANW: begin
                    r_last       <= w_rrow;
                    r_scan_first <= 1'b0;
                    if (!r_scan_first) begin
                        for (int p = 0; p < psa_pkg::MAX_PUMPS; p++) begin
                            if (!r_last[p] && w_rrow[p]) r_a01[p] <= r_a01[p] - 1'b1;
                            else if (r_last[p] && !w_rrow[p]) r_a10[p] <= r_a10[p] - 1'b1;
                        end
                    end
                    if (r_addr == RA'(r_hour - 1'b1)) begin
                        r_i     <= psa_pkg::CW'(1);
                        r_state <= S_SORTI;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SORTI: begin
                    if (!r_sort_en || r_i >= r_n) begin
                        r_i     <= '0;
                        r_state <= S_WALK;
                    end else begin
                        r_v     <= r_ord[r_i[psa_pkg::PW-1:0]];
                        r_k     <= r_i;
                        r_state <= S_SORTC;
                    end
                end
                S_SORTC: begin
                    if (r_k != '0 && w_first) begin
                        r_ord[r_k[psa_pkg::PW-1:0]] <= w_b;
                        r_k <= r_k - 1'b1;
                    end else begin
                        r_ord[r_k[psa_pkg::PW-1:0]] <= r_v;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SORTI;
                    end
                end
                S_WALK: begin
                    if (r_i >= r_n || r_cnt == '0) begin
                        if (r_cnt != '0) r_ok <= 1'b0;
                        r_state <= S_WRITE;
                    end else if (w_qbit != r_on) begin
                        if (w_qallow <= 0) begin
                            r_ok    <= 1'b0;
                            r_state <= S_WRITE;
                        end else begin
                            r_row[w_q] <= r_on;
                            r_cnt      <= r_cnt - 1'b1;
                            r_i        <= r_i + 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_addr  <= RA'(r_hour);
                    r_wrow  <= r_row;
                    r_wcnt  <= r_want;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res.pump_row           <= r_row;
                    r_res.feasible           <= r_ok && (r_want == r_old || r_cnt == '0);
                    r_res.remaining_switches <= (r_want == r_old) ? '0 : r_cnt;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
    a_write_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_OUT && r_we)) else $error("store write lost");
    a_out_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_ovalid) else $error("result dropped");
`endif
endmodule

[verif/tb_pump_switch_assigner_top.sv]
`timescale 1ns / 1ps
// testbench for the pump switch assigner: random and directed hours against a row predictor
module tb_pump_switch_assigner_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    psa_if #(.T(psa_pkg::t_request)) req_ch ();
    psa_if #(.T(psa_pkg::t_result))  res_ch ();

    pump_switch_assigner_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .i_req(req_ch), .o_res(res_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [psa_pkg::ROW_W-1:0] rows_q [0:psa_pkg::HOURS];
    logic [psa_pkg::CW-1:0]    counts_q [0:psa_pkg::HOURS];
    logic [psa_pkg::CW-1:0]    cfg_pumps;
    logic [4:0]                cfg_limit;
    logic                      cfg_sort;

    psa_pkg::t_request pending_reqs[$];
    psa_pkg::t_result  expected_results[$];
    int       errors = 0;
    int       quiet_cycles = 0;
    int       hold_cycles = 0;
    bit       src_idle_en = 1'b1;
    bit       sink_idle_en = 1'b1;
    bit       sink_hold = 1'b0;

    function automatic psa_pkg::t_result assign_row(psa_pkg::t_request rq);
        psa_pkg::t_result r;
        int n, cnt;
        int allow01[psa_pkg::MAX_PUMPS], allow10[psa_pkg::MAX_PUMPS];
        int ord[psa_pkg::MAX_PUMPS];
        int v, k, q, pa, pb, sa, sb;
        logic [psa_pkg::ROW_W-1:0] row, active, a, b;
        logic [psa_pkg::CW-1:0] y_old;
        bit on_mode, ok, first;
        r = '0;
        if (rq.hour < 1 || rq.hour > psa_pkg::HOURS) return r;
        n = (int'(cfg_pumps) > psa_pkg::MAX_PUMPS) ? psa_pkg::MAX_PUMPS : int'(cfg_pumps);
        active = '0;
        for (int p = 0; p < n; p++) active[p] = 1'b1;
        y_old = counts_q[rq.hour-1];
        row = rows_q[rq.hour-1] & active;
        ok = 1'b1;
        cnt = 0;
        if (rq.pumps_on != y_old) begin
            for (int p = 0; p < n; p++) begin
                allow01[p] = int'(cfg_limit);
                allow10[p] = int'(cfg_limit);
                for (int i = 2; i < int'(rq.hour); i++) begin
                    a = rows_q[i-1];
                    b = rows_q[i];
                    if (!a[p] && b[p]) allow01[p]--;
                    else if (a[p] && !b[p]) allow10[p]--;
                end
                ord[p] = p;
            end
            on_mode = rq.pumps_on > y_old;
            cnt = on_mode ? int'(rq.pumps_on) - int'(y_old) : int'(y_old) - int'(rq.pumps_on);
            if (cfg_sort) begin
                for (int i = 1; i < n; i++) begin
                    v = ord[i];
                    k = i;
                    while (k > 0) begin
                        pa = on_mode ? allow01[v] : allow10[v];
                        pb = on_mode ? allow01[ord[k-1]] : allow10[ord[k-1]];
                        sa = on_mode ? allow10[v] : allow01[v];
                        sb = on_mode ? allow10[ord[k-1]] : allow01[ord[k-1]];
                        if (pa != pb) first = pa > pb;
                        else if (sa != sb) first = sa > sb;
                        else first = v < ord[k-1];
                        if (!first) break;
                        ord[k] = ord[k-1];
                        k--;
                    end
                    ord[k] = v;
                end
            end
            for (int i = 0; i < n; i++) begin
                q = ord[i];
                if (cnt <= 0) break;
                if (on_mode && !row[q]) begin
                    if (allow01[q] <= 0) begin
                        ok = 1'b0;
                        break;
                    end
                    row[q] = 1'b1;
                    cnt--;
                end else if (!on_mode && row[q]) begin
                    if (allow10[q] <= 0) begin
                        ok = 1'b0;
                        break;
                    end
                    row[q] = 1'b0;
                    cnt--;
                end
            end
            if (cnt != 0) ok = 1'b0;
        end
        rows_q[rq.hour] = row;
        counts_q[rq.hour] = rq.pumps_on;
        r.pump_row = row;
        r.feasible = ok;
        r.remaining_switches = cnt[psa_pkg::CW-1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 &&
                    !(src_idle_en && $urandom_range(99) < 24)) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_reqs.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // sink readiness, with a long hold counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_cycles  <= 0;
        end else if (hold_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else if (sink_hold) begin
            res_ch.ready <= 1'b0;
            hold_cycles  <= 1500;
        end else begin
            res_ch.ready <= !(sink_idle_en && $urandom_range(99) < 24);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        psa_pkg::t_result e;
        psa_pkg::t_result act;
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(assign_row(req_ch.data));
            end
            if (res_ch.valid && res_ch.ready) begin
                act = res_ch.data;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction %h", act);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (act.pump_row !== e.pump_row) begin
                        $error("pump_row exp %h got %h", e.pump_row, act.pump_row);
                        errors++;
                    end
                    if (act.feasible !== e.feasible) begin
                        $error("feasible exp %b got %b", e.feasible, act.feasible);
                        errors++;
                    end
                    if (act.remaining_switches !== e.remaining_switches) begin
                        $error("remaining_switches exp %0d got %0d",
                               e.remaining_switches, act.remaining_switches);
                        errors++;
                    end
                end
            end
            if (quiet_cycles > 20000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [3:0] addr, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            psa_pkg::REG_PUMP_COUNT: cfg_pumps = val[psa_pkg::CW-1:0];
            psa_pkg::REG_ACT_LIMIT:  cfg_limit = val[4:0];
            default:                 cfg_sort  = val[0];
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic push_req(int h, int y);
        psa_pkg::t_request rq;
        rq.hour = psa_pkg::HW'(h);
        rq.pumps_on = psa_pkg::CW'(y);
        pending_reqs.push_back(rq);
    endtask

    // a well-formed schedule walks hours 1..24 in order, with some noise
    task automatic push_schedule(int maxy);
        for (int h = 1; h <= psa_pkg::HOURS; h++) begin
            if ($urandom_range(19) == 0)
                push_req($urandom_range(31), $urandom_range(15));
            else if ($urandom_range(9) == 0)
                push_req(h, $urandom_range(15));
            else
                push_req(h, $urandom_range(maxy));
        end
    endtask

    initial begin
        for (int i = 0; i <= psa_pkg::HOURS; i++) begin
            rows_q[i] = '0;
            counts_q[i] = '0;
        end
        cfg_pumps = psa_pkg::PUMP_COUNT_RST;
        cfg_limit = psa_pkg::ACT_LIMIT_RST;
        cfg_sort  = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (30) @(posedge i_clk);

        // directed: out of range, unchanged count, extremes, too many pumps
        push_req(0, 3);
        push_req(25, 8);
        push_req(31, 15);
        push_req(1, 0);
        push_req(2, 8);
        push_req(3, 0);
        push_req(4, 8);
        push_req(5, 8);
        push_req(6, 0);
        push_req(7, 8);
        push_req(8, 15);
        push_req(9, 1);
        push_req(24, 4);
        drain();
        reg_write(psa_pkg::REG_PUMP_COUNT, 0);
        push_req(10, 3);
        push_req(11, 3);
        drain();
        reg_write(psa_pkg::REG_PUMP_COUNT, 15);
        reg_write(psa_pkg::REG_ACT_LIMIT, 0);
        reg_write(psa_pkg::REG_SORT_EN, 0);
        push_req(12, 5);
        push_req(13, 2);
        drain();
        reg_write(psa_pkg::REG_ACT_LIMIT, 31);
        push_req(14, 7);
        push_req(15, 0);
        push_req(16, 9);
        drain();

        // random phases with changing settings
        for (int ph = 0; ph < 54; ph++) begin
            reg_write(psa_pkg::REG_PUMP_COUNT, (ph % 9 == 0) ? 8 : $urandom_range(15));
            reg_write(psa_pkg::REG_ACT_LIMIT, (ph % 7 == 0) ? 24 : $urandom_range(31));
            reg_write(psa_pkg::REG_SORT_EN, $urandom_range(1));
            src_idle_en  = (ph % 10 != 5);
            sink_idle_en = (ph % 10 != 5);
            push_schedule((ph % 4 == 0) ? 15 : 8);
            if (ph == 20) begin
                // receiver holds off while the sender keeps offering
                sink_hold = 1'b1;
                wait (hold_cycles > 0);
                sink_hold = 1'b0;
            end
            drain();
        end
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
